>>> rtl/core/json_token_stream_parser_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects clk and rst_n in scope.
`ifndef JSON_TOKEN_STREAM_PARSER_MACROS_SVH
`define JSON_TOKEN_STREAM_PARSER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds at every clock edge.
`define TSP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> rtl/core/tsp_pkg.sv
// Shared types, codes and helper functions of the JSON token stream parser.
// No dependencies.
package tsp_pkg;

    localparam int DEFAULT_MAX_DEPTH = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);
    localparam logic [5:0] NEST_LIMIT_RESET = 6'd32;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_SLASH = 4'd1,
        M_LINE  = 4'd2,
        M_BLOCK = 4'd3,
        M_STAR  = 4'd4,
        M_STRV  = 4'd5,
        M_STRN  = 4'd6,
        M_ESCV  = 4'd7,
        M_ESCN  = 4'd8,
        M_BARE  = 4'd9
    } mode_t;

    typedef enum logic [1:0] {
        EX_VALUE = 2'd0,
        EX_NAME  = 2'd1,
        EX_COLON = 2'd2,
        EX_SEP   = 2'd3
    } expect_t;

    localparam logic [3:0] K_CONTENT   = 4'd0;
    localparam logic [3:0] K_BEGIN_OBJ = 4'd1;
    localparam logic [3:0] K_END_OBJ   = 4'd2;
    localparam logic [3:0] K_BEGIN_ARR = 4'd3;
    localparam logic [3:0] K_END_ARR   = 4'd4;
    localparam logic [3:0] K_NAME_END  = 4'd5;
    localparam logic [3:0] K_STR_END   = 4'd6;
    localparam logic [3:0] K_NULL      = 4'd7;
    localparam logic [3:0] K_BOOL      = 4'd8;
    localparam logic [3:0] K_FLOAT     = 4'd9;
    localparam logic [3:0] K_SIGNED    = 4'd10;
    localparam logic [3:0] K_UNSIGNED  = 4'd11;
    localparam logic [3:0] K_END_DOC   = 4'd12;
    localparam logic [3:0] K_ERROR     = 4'd13;

    localparam logic [3:0] E_COMMA       = 4'd1;
    localparam logic [3:0] E_COLON       = 4'd2;
    localparam logic [3:0] E_UNQUOTED    = 4'd3;
    localparam logic [3:0] E_SLASH       = 4'd4;
    localparam logic [3:0] E_OPEN_CMT    = 4'd5;
    localparam logic [3:0] E_OPEN_STR    = 4'd6;
    localparam logic [3:0] E_ESCAPE      = 4'd7;
    localparam logic [3:0] E_BAD_TOKEN   = 4'd8;
    localparam logic [3:0] E_TOO_DEEP    = 4'd9;
    localparam logic [3:0] E_BAD_CLOSE   = 4'd10;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       bval;
        logic [3:0] err;
    } result_t;

    // Up to two results caused by one byte; r0 goes out first.
    typedef struct packed {
        result_t    r1;
        result_t    r0;
        logic [1:0] cnt;
    } bundle_t;

    function automatic result_t ev_res(input logic [3:0] kind);
        result_t r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic result_t fail_res(input logic [3:0] code);
        result_t r;
        r = '0;
        r.kind = K_ERROR;
        r.err  = code;
        return r;
    endfunction

    function automatic result_t byte_res(input logic [7:0] c);
        result_t r;
        r = '0;
        r.kind = K_CONTENT;
        r.data = c;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_num_start(input logic [7:0] c);
        return is_digit(c) || (c == "+") || (c == "-") || (c == ".");
    endfunction

    function automatic logic is_bare(input logic [7:0] c);
        return is_num_start(c) || is_alpha(c);
    endfunction

    // Keyword letters by position: null, true, false; zero past the end.
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        case (k)
            2'd0:
            begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'd0;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            2'd2:
            begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_match(input logic [2:0] pos, input logic [7:0] c);
        logic [2:0] m;
        m[0] = (kw_char(2'd0, pos) == c);
        m[1] = (kw_char(2'd1, pos) == c);
        m[2] = (kw_char(2'd2, pos) == c);
        return m;
    endfunction

    // Bit 8 set marks an invalid escape.
    function automatic logic [8:0] unescape(input logic [7:0] c);
        logic [8:0] d;
        case (c)
            "\\", "/", "\"": d = {1'b0, c};
            "b":             d = 9'd8;
            "f":             d = 9'd12;
            "n":             d = 9'd10;
            "r":             d = 9'd13;
            "t":             d = 9'd9;
            default:         d = 9'h100;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/core/tsp_front.sv
// Front end: lexer and structure checker; turns each byte into a result bundle.
// Depends on tsp_pkg and json_token_stream_parser_macros.svh.
`include "json_token_stream_parser_macros.svh"

module tsp_front #(
    parameter int MAX_DEPTH = tsp_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [5:0]       cfg_value,
    input  logic             step,
    input  logic [7:0]       c,
    output logic             push,
    output tsp_pkg::bundle_t bundle
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SW = $clog2(MAX_DEPTH);
    localparam int CW = (DW > 6) ? DW : 6;
    localparam logic [CW-1:0] MAXD_C = CW'(MAX_DEPTH);

    tsp_pkg::mode_t   mode_reg, mode_next;
    tsp_pkg::expect_t ex_reg, ex_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic             lto_reg, lto_next;
    logic [7:0]       first_reg, first_next;
    logic             dot_reg, dot_next;
    logic [2:0]       km_reg, km_next;
    logic [2:0]       len_reg, len_next;
    logic             err_reg, err_next;
    logic [5:0]       limit_reg;
    logic [MAX_DEPTH-1:0] stack_reg;

    // idle-byte handling, shared by idle mode, bare token end, zero byte in line comment
    tsp_pkg::mode_t   id_mode;
    tsp_pkg::expect_t id_ex;
    logic [DW-1:0]    id_depth;
    logic             id_lto, id_dot, id_err, id_v, id_we, id_wval;
    logic [7:0]       id_first;
    logic [2:0]       id_km, id_len;
    tsp_pkg::result_t id_res;

    logic [CW-1:0]    lim_c;
    logic             top_valid, top_obj;
    logic [DW-1:0]    depth_m1;
    logic             want_obj, close_ok;

    logic             va, vb;
    tsp_pkg::result_t ra, rb;
    logic             use_idle;
    tsp_pkg::result_t bare_res;
    logic             bare_fail;
    logic [8:0]       esc;

    assign depth_m1  = depth_reg - DW'(1);
    assign top_valid = (depth_reg != '0);
    assign top_obj   = stack_reg[depth_m1[SW-1:0]];
    assign lim_c     = (CW'(limit_reg) < MAXD_C) ? CW'(limit_reg) : MAXD_C;
    assign want_obj  = (c == "}");
    assign close_ok  = top_valid && (top_obj == want_obj) &&
                       ((ex_reg == tsp_pkg::EX_SEP) ||
                        (lto_reg && (ex_reg == (want_obj ? tsp_pkg::EX_NAME
                                                         : tsp_pkg::EX_VALUE))));

    always_comb
    begin
        id_mode  = tsp_pkg::M_IDLE;
        id_ex    = ex_reg;
        id_depth = depth_reg;
        id_lto   = lto_reg;
        id_first = first_reg;
        id_dot   = dot_reg;
        id_km    = km_reg;
        id_len   = len_reg;
        id_err   = 1'b0;
        id_v     = 1'b0;
        id_res   = '0;
        id_we    = 1'b0;
        id_wval  = 1'b0;
        case (c)
            " ", "\t", "\n", "\r":
            begin
            end
            8'd0:
            begin
                id_v     = 1'b1;
                id_res   = tsp_pkg::ev_res(tsp_pkg::K_END_DOC);
                id_ex    = tsp_pkg::EX_VALUE;
                id_depth = '0;
                id_lto   = 1'b0;
                id_first = '0;
                id_dot   = 1'b0;
                id_km    = '0;
                id_len   = '0;
            end
            "/":
            begin
                id_mode = tsp_pkg::M_SLASH;
            end
            "{", "[":
            begin
                id_v = 1'b1;
                if (ex_reg == tsp_pkg::EX_COLON)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_COLON);
                    id_err = 1'b1;
                end
                else if (ex_reg == tsp_pkg::EX_SEP)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_COMMA);
                    id_err = 1'b1;
                end
                else if (ex_reg == tsp_pkg::EX_NAME)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_UNQUOTED);
                    id_err = 1'b1;
                end
                else if (CW'(depth_reg) >= lim_c)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_TOO_DEEP);
                    id_err = 1'b1;
                end
                else
                begin
                    id_we    = 1'b1;
                    id_wval  = (c == "{");
                    id_depth = depth_reg + DW'(1);
                    id_res   = tsp_pkg::ev_res((c == "{") ? tsp_pkg::K_BEGIN_OBJ
                                                          : tsp_pkg::K_BEGIN_ARR);
                    id_ex    = (c == "{") ? tsp_pkg::EX_NAME : tsp_pkg::EX_VALUE;
                    id_lto   = 1'b1;
                end
            end
            "}", "]":
            begin
                id_v = 1'b1;
                if (ex_reg == tsp_pkg::EX_COLON)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_COLON);
                    id_err = 1'b1;
                end
                else if (!close_ok)
                begin
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_BAD_CLOSE);
                    id_err = 1'b1;
                end
                else
                begin
                    id_depth = depth_m1;
                    id_res   = tsp_pkg::ev_res(want_obj ? tsp_pkg::K_END_OBJ
                                                        : tsp_pkg::K_END_ARR);
                    id_ex    = (depth_m1 == '0) ? tsp_pkg::EX_VALUE : tsp_pkg::EX_SEP;
                    id_lto   = 1'b0;
                end
            end
            ",":
            begin
                if (ex_reg == tsp_pkg::EX_SEP)
                begin
                    id_ex  = (top_valid && top_obj) ? tsp_pkg::EX_NAME : tsp_pkg::EX_VALUE;
                    id_lto = 1'b0;
                end
                else
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res((ex_reg == tsp_pkg::EX_COLON)
                                               ? tsp_pkg::E_COLON : tsp_pkg::E_COMMA);
                end
            end
            ":":
            begin
                if (ex_reg == tsp_pkg::EX_COLON)
                begin
                    id_ex  = tsp_pkg::EX_VALUE;
                    id_lto = 1'b0;
                end
                else
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res((ex_reg == tsp_pkg::EX_SEP)
                                               ? tsp_pkg::E_COMMA : tsp_pkg::E_COLON);
                end
            end
            "\"":
            begin
                if (ex_reg == tsp_pkg::EX_COLON)
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_COLON);
                end
                else if (ex_reg == tsp_pkg::EX_SEP)
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_COMMA);
                end
                else if (ex_reg == tsp_pkg::EX_NAME)
                begin
                    id_mode = tsp_pkg::M_STRN;
                    id_ex   = tsp_pkg::EX_COLON;
                    id_lto  = 1'b0;
                end
                else
                begin
                    id_mode = tsp_pkg::M_STRV;
                    id_ex   = (depth_reg == '0) ? tsp_pkg::EX_VALUE : tsp_pkg::EX_SEP;
                    id_lto  = 1'b0;
                end
            end
            default:
            begin
                if (!tsp_pkg::is_bare(c))
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res(tsp_pkg::E_BAD_TOKEN);
                end
                else if (ex_reg != tsp_pkg::EX_VALUE)
                begin
                    id_v   = 1'b1;
                    id_err = 1'b1;
                    id_res = tsp_pkg::fail_res((ex_reg == tsp_pkg::EX_COLON)
                                               ? tsp_pkg::E_COLON
                                               : (ex_reg == tsp_pkg::EX_SEP)
                                               ? tsp_pkg::E_COMMA : tsp_pkg::E_UNQUOTED);
                end
                else
                begin
                    id_mode  = tsp_pkg::M_BARE;
                    id_first = c;
                    id_ex    = (depth_reg == '0) ? tsp_pkg::EX_VALUE : tsp_pkg::EX_SEP;
                    id_lto   = 1'b0;
                    id_len   = 3'd1;
                    if (tsp_pkg::is_num_start(c))
                    begin
                        id_v   = 1'b1;
                        id_res = tsp_pkg::byte_res(c);
                        id_dot = (c == ".");
                        id_km  = 3'b111;
                    end
                    else
                    begin
                        id_dot = 1'b0;
                        id_km  = tsp_pkg::kw_match(3'd0, c);
                    end
                end
            end
        endcase
    end

    // result of closing a bare token
    always_comb
    begin
        bare_fail = 1'b0;
        bare_res  = '0;
        if (tsp_pkg::is_num_start(first_reg))
        begin
            bare_res = tsp_pkg::ev_res(dot_reg ? tsp_pkg::K_FLOAT
                                       : (first_reg == "-") ? tsp_pkg::K_SIGNED
                                       : tsp_pkg::K_UNSIGNED);
        end
        else if (km_reg[0] && (len_reg == 3'd4))
        begin
            bare_res = tsp_pkg::ev_res(tsp_pkg::K_NULL);
        end
        else if (km_reg[1] && (len_reg == 3'd4))
        begin
            bare_res      = tsp_pkg::ev_res(tsp_pkg::K_BOOL);
            bare_res.bval = 1'b1;
        end
        else if (km_reg[2] && (len_reg == 3'd5))
        begin
            bare_res = tsp_pkg::ev_res(tsp_pkg::K_BOOL);
        end
        else
        begin
            bare_fail = 1'b1;
            bare_res  = tsp_pkg::fail_res(tsp_pkg::E_BAD_TOKEN);
        end
    end

    assign esc = tsp_pkg::unescape(c);

    always_comb
    begin
        mode_next  = mode_reg;
        ex_next    = ex_reg;
        depth_next = depth_reg;
        lto_next   = lto_reg;
        first_next = first_reg;
        dot_next   = dot_reg;
        km_next    = km_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        va         = 1'b0;
        vb         = 1'b0;
        ra         = '0;
        rb         = '0;
        use_idle   = 1'b0;
        unique case (mode_reg)
            tsp_pkg::M_IDLE:
            begin
                use_idle = 1'b1;
            end
            tsp_pkg::M_SLASH:
            begin
                if (c == "/")
                begin
                    mode_next = tsp_pkg::M_LINE;
                end
                else if (c == "*")
                begin
                    mode_next = tsp_pkg::M_BLOCK;
                end
                else
                begin
                    vb       = 1'b1;
                    rb       = tsp_pkg::fail_res(tsp_pkg::E_SLASH);
                    err_next = 1'b1;
                end
            end
            tsp_pkg::M_LINE:
            begin
                if (c == 8'd0)
                begin
                    use_idle = 1'b1;
                end
                else if (c == "\n")
                begin
                    mode_next = tsp_pkg::M_IDLE;
                end
            end
            tsp_pkg::M_BLOCK, tsp_pkg::M_STAR:
            begin
                if (c == 8'd0)
                begin
                    vb       = 1'b1;
                    rb       = tsp_pkg::fail_res(tsp_pkg::E_OPEN_CMT);
                    err_next = 1'b1;
                end
                else if (c == "*")
                begin
                    mode_next = tsp_pkg::M_STAR;
                end
                else if ((mode_reg == tsp_pkg::M_STAR) && (c == "/"))
                begin
                    mode_next = tsp_pkg::M_IDLE;
                end
                else
                begin
                    mode_next = tsp_pkg::M_BLOCK;
                end
            end
            tsp_pkg::M_STRV, tsp_pkg::M_STRN:
            begin
                vb = 1'b1;
                if (c == 8'd0)
                begin
                    rb       = tsp_pkg::fail_res(tsp_pkg::E_OPEN_STR);
                    err_next = 1'b1;
                end
                else if (c == "\"")
                begin
                    rb        = tsp_pkg::ev_res((mode_reg == tsp_pkg::M_STRN)
                                                ? tsp_pkg::K_NAME_END : tsp_pkg::K_STR_END);
                    mode_next = tsp_pkg::M_IDLE;
                end
                else if (c == "\\")
                begin
                    vb        = 1'b0;
                    mode_next = (mode_reg == tsp_pkg::M_STRN) ? tsp_pkg::M_ESCN
                                                              : tsp_pkg::M_ESCV;
                end
                else
                begin
                    rb = tsp_pkg::byte_res(c);
                end
            end
            tsp_pkg::M_ESCV, tsp_pkg::M_ESCN:
            begin
                vb = 1'b1;
                if (esc[8])
                begin
                    rb       = tsp_pkg::fail_res(tsp_pkg::E_ESCAPE);
                    err_next = 1'b1;
                end
                else
                begin
                    rb        = tsp_pkg::byte_res(esc[7:0]);
                    mode_next = (mode_reg == tsp_pkg::M_ESCN) ? tsp_pkg::M_STRN
                                                              : tsp_pkg::M_STRV;
                end
            end
            tsp_pkg::M_BARE:
            begin
                if (tsp_pkg::is_bare(c))
                begin
                    if (tsp_pkg::is_num_start(first_reg))
                    begin
                        vb       = 1'b1;
                        rb       = tsp_pkg::byte_res(c);
                        dot_next = dot_reg | (c == ".");
                    end
                    else
                    begin
                        km_next = km_reg & tsp_pkg::kw_match(len_reg, c);
                    end
                    if (len_reg != 3'd7)
                    begin
                        len_next = len_reg + 3'd1;
                    end
                end
                else
                begin
                    va        = 1'b1;
                    ra        = bare_res;
                    mode_next = tsp_pkg::M_IDLE;
                    if (bare_fail)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        use_idle = 1'b1;
                    end
                end
            end
            default:
            begin
                use_idle = 1'b1;
            end
        endcase
        if (use_idle)
        begin
            mode_next  = id_mode;
            ex_next    = id_ex;
            depth_next = id_depth;
            lto_next   = id_lto;
            first_next = id_first;
            dot_next   = id_dot;
            km_next    = id_km;
            len_next   = id_len;
            err_next   = id_err;
            vb         = id_v;
            rb         = id_res;
        end
        bundle.cnt = {1'b0, va} + {1'b0, vb};
        bundle.r0  = va ? ra : rb;
        bundle.r1  = rb;
    end

    assign push = step && !err_reg && (bundle.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tsp_pkg::M_IDLE;
            ex_reg    <= tsp_pkg::EX_VALUE;
            depth_reg <= '0;
            lto_reg   <= 1'b0;
            first_reg <= '0;
            dot_reg   <= 1'b0;
            km_reg    <= '0;
            len_reg   <= '0;
            err_reg   <= 1'b0;
            limit_reg <= tsp_pkg::NEST_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_value;
            end
            if (step && !err_reg)
            begin
                mode_reg  <= mode_next;
                ex_reg    <= ex_next;
                depth_reg <= depth_next;
                lto_reg   <= lto_next;
                first_reg <= first_next;
                dot_reg   <= dot_next;
                km_reg    <= km_next;
                len_reg   <= len_next;
                err_reg   <= err_next;
            end
        end
    end

    // level stack: written only by an accepted opener, no reset
    always_ff @(posedge clk)
    begin
        if (step && !err_reg && use_idle && id_we)
        begin
            stack_reg[depth_reg[SW-1:0]] <= id_wval;
        end
    end

    `TSP_ASSERT_ALWAYS(a_depth_bound, (depth_reg <= DW'(MAX_DEPTH)), "nesting depth overflow")
    `TSP_ASSERT_IMPL(a_err_sticky, $past(err_reg), err_reg, "error latch dropped")
    `TSP_ASSERT_IMPL(a_quiet_after_err, err_reg, !push, "result after error")

endmodule

>>> rtl/core/tsp_queue.sv
// Short queue of result bundles between the lexer and the output serializer.
// Depends on tsp_pkg and json_token_stream_parser_macros.svh.
`include "json_token_stream_parser_macros.svh"

module tsp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tsp_pkg::bundle_t wr_data,
    output logic             ready,
    input  logic             pop,
    output logic             not_empty,
    output tsp_pkg::bundle_t rd_data
);

    tsp_pkg::bundle_t                 mem [tsp_pkg::QUEUE_DEPTH];
    logic [tsp_pkg::QPTR_W-1:0]       wr_reg, rd_reg;
    logic [tsp_pkg::QCNT_W-1:0]       cnt_reg;

    assign ready     = (cnt_reg != tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + tsp_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + tsp_pkg::QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + tsp_pkg::QCNT_W'(push) - tsp_pkg::QCNT_W'(pop);
        end
    end

    `TSP_ASSERT_IMPL(a_no_overrun, push, ready, "push into full queue")
    `TSP_ASSERT_IMPL(a_no_underrun, pop, not_empty, "pop from empty queue")
    `TSP_ASSERT_ALWAYS(a_cnt_bound, (cnt_reg <= tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH)),
        "queue count out of range")

endmodule

>>> rtl/core/tsp_back.sv
// Back end: sends the results of each bundle one beat at a time, marks the last.
// Depends on tsp_pkg.
module tsp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tsp_pkg::bundle_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output tsp_pkg::result_t out_res,
    output logic             out_last
);

    logic sel_reg, sel_next;

    assign out_valid = q_valid;
    assign out_res   = sel_reg ? q_data.r1 : q_data.r0;
    assign out_last  = sel_reg || (q_data.cnt == 2'd1);
    assign q_pop     = out_valid && out_ready && out_last;

    always_comb
    begin
        sel_next = sel_reg;
        if (out_valid && out_ready)
        begin
            sel_next = !out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule

>>> rtl/core/json_token_stream_parser.sv
// JSON token stream parser. Takes one text byte per beat on the slave side and
// returns one event per beat on the master side. The lexer takes a byte every
// cycle whenever the four-entry result queue has room; a byte yields zero, one
// or two events (a bare token closed by a structural byte gives two), and the
// output drains one event per cycle, so sustained input rate is one byte per
// cycle unless the sink stalls or two-event bytes arrive faster than the
// output can drain. tlast marks the final event caused by a byte. After the
// first error event, bytes are still taken but produce nothing until reset.
// The user must write nest_limit through the cfg channel while the stream is idle; the block does not check.
module json_token_stream_parser #(
    parameter int MAX_DEPTH = tsp_pkg::DEFAULT_MAX_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // config: nest_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    // text_byte [7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // event_kind [3:0], content_byte [11:4], bool_value [12], error_code [16:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic             step, push, q_ready, q_valid, q_pop;
    tsp_pkg::bundle_t bundle, q_data;
    tsp_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign step      = s_tvalid && s_tready;

    tsp_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .step      (step),
        .c         (s_tdata),
        .push      (push),
        .bundle    (bundle)
    );

    // hold bundles while the sink stalls
    tsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (bundle),
        .ready     (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_data)
    );

    tsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'd0, res.err, res.bval, res.data, res.kind};

endmodule

>>> tb/sv/tb_json_token_stream_parser.sv
// Self-checking testbench for json_token_stream_parser: streams generated JSON
// text, predicts the event stream in a local tokenizer, and checks every beat.
// Depends on tsp_pkg and the parser RTL.
module tb_json_token_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0] kind;
        logic [7:0] data;
        logic       bval;
        logic [3:0] err;
        logic       last;
    } event_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // text_byte [7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // event_kind [3:0], content_byte [11:4], bool_value [12],
                            // error_code [16:13]
    logic        m_tlast;

    // Bytes waiting for the driver, and events the parser still owes us.
    byte unsigned text_q[$];
    event_t       pending_events[$];
    event_t       byte_events[$];

    bit byte_taken;
    bit hold_input;
    bit steady;
    int fail_count;

    // Predictor state.
    tsp_pkg::mode_t   lx_mode;
    bit               lvl_is_obj[tsp_pkg::DEFAULT_MAX_DEPTH];
    int               depth;
    tsp_pkg::expect_t want;
    bit               just_opened;
    byte unsigned     first_ch;
    bit               saw_dot;
    bit [2:0]         kw_alive;
    int               bare_len;
    bit               err_seen;
    logic [5:0]       limit_reg;

    string kw_word[3] = '{"null", "true", "false"};

    localparam int TK_OPEN   = 0;
    localparam int TK_STRING = 1;
    localparam int TK_BARE   = 2;
    localparam int TK_COMMA  = 3;
    localparam int TK_COLON  = 4;

    json_token_stream_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void emit_event(logic [3:0] kind, logic [7:0] data, logic bval,
                                       logic [3:0] err);
        event_t e;
        e.kind = kind;
        e.data = data;
        e.bval = bval;
        e.err  = err;
        e.last = 1'b0;
        byte_events.push_back(e);
    endfunction

    function automatic void raise_error(logic [3:0] code);
        emit_event(tsp_pkg::K_ERROR, 8'd0, 1'b0, code);
        err_seen = 1'b1;
    endfunction

    function automatic void new_document();
        lx_mode     = tsp_pkg::M_IDLE;
        depth       = 0;
        want        = tsp_pkg::EX_VALUE;
        just_opened = 1'b0;
        first_ch    = 8'd0;
        saw_dot     = 1'b0;
        kw_alive    = 3'b000;
        bare_len    = 0;
    endfunction

    // 1 object, 0 array, 2 when no level is open
    function automatic int innermost_kind();
        if (depth == 0 || depth > tsp_pkg::DEFAULT_MAX_DEPTH)
            return 2;
        return int'(lvl_is_obj[depth - 1]);
    endfunction

    function automatic void value_done();
        want        = (depth == 0) ? tsp_pkg::EX_VALUE : tsp_pkg::EX_SEP;
        just_opened = 1'b0;
    endfunction

    function automatic bit is_num_lead(byte unsigned c);
        return (c >= "0" && c <= "9") || c == "+" || c == "-" || c == ".";
    endfunction

    function automatic bit is_bare_byte(byte unsigned c);
        return is_num_lead(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Returns 1 when a value may start, 2 when a member name may start.
    function automatic int accept_token(int tk);
        case (want)
            tsp_pkg::EX_COLON:
            begin
                if (tk == TK_COLON)
                begin
                    want        = tsp_pkg::EX_VALUE;
                    just_opened = 1'b0;
                end
                else
                    raise_error(tsp_pkg::E_COLON);
                return 0;
            end
            tsp_pkg::EX_SEP:
            begin
                if (tk == TK_COMMA)
                begin
                    want        = (innermost_kind() == 1) ? tsp_pkg::EX_NAME
                                                          : tsp_pkg::EX_VALUE;
                    just_opened = 1'b0;
                end
                else
                    raise_error(tsp_pkg::E_COMMA);
                return 0;
            end
            tsp_pkg::EX_NAME:
            begin
                if (tk == TK_STRING)
                    return 2;
                raise_error(tk == TK_COMMA ? tsp_pkg::E_COMMA :
                            tk == TK_COLON ? tsp_pkg::E_COLON : tsp_pkg::E_UNQUOTED);
                return 0;
            end
            default:
            begin
                if (tk == TK_COMMA)
                begin
                    raise_error(tsp_pkg::E_COMMA);
                    return 0;
                end
                if (tk == TK_COLON)
                begin
                    raise_error(tsp_pkg::E_COLON);
                    return 0;
                end
                return 1;
            end
        endcase
    endfunction

    function automatic void close_level(bit obj);
        bit ok;
        if (want == tsp_pkg::EX_COLON)
        begin
            raise_error(tsp_pkg::E_COLON);
            return;
        end
        ok = innermost_kind() == int'(obj) &&
             (want == tsp_pkg::EX_SEP ||
              (just_opened && want == (obj ? tsp_pkg::EX_NAME : tsp_pkg::EX_VALUE)));
        if (!ok)
        begin
            raise_error(tsp_pkg::E_BAD_CLOSE);
            return;
        end
        depth--;
        emit_event(obj ? tsp_pkg::K_END_OBJ : tsp_pkg::K_END_ARR, 8'd0, 1'b0, 4'd0);
        value_done();
    endfunction

    function automatic void open_level(bit obj);
        int cap;
        cap = (limit_reg < tsp_pkg::DEFAULT_MAX_DEPTH) ? int'(limit_reg)
                                                       : tsp_pkg::DEFAULT_MAX_DEPTH;
        if (accept_token(TK_OPEN) != 1)
            return;
        if (depth >= cap)
        begin
            raise_error(tsp_pkg::E_TOO_DEEP);
            return;
        end
        lvl_is_obj[depth] = obj;
        depth++;
        emit_event(obj ? tsp_pkg::K_BEGIN_OBJ : tsp_pkg::K_BEGIN_ARR, 8'd0, 1'b0, 4'd0);
        want        = obj ? tsp_pkg::EX_NAME : tsp_pkg::EX_VALUE;
        just_opened = 1'b1;
    endfunction

    function automatic void bare_char(byte unsigned c);
        string w;
        if (is_num_lead(first_ch))
        begin
            emit_event(tsp_pkg::K_CONTENT, c, 1'b0, 4'd0);
            if (c == ".")
                saw_dot = 1'b1;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                w = kw_word[k];
                if (kw_alive[k] && (bare_len >= w.len() || w[bare_len] != c))
                    kw_alive[k] = 1'b0;
            end
        end
        if (bare_len < 7)
            bare_len++;
    endfunction

    function automatic void finish_bare();
        lx_mode = tsp_pkg::M_IDLE;
        if (is_num_lead(first_ch))
            emit_event(saw_dot ? tsp_pkg::K_FLOAT :
                       (first_ch == "-" ? tsp_pkg::K_SIGNED : tsp_pkg::K_UNSIGNED),
                       8'd0, 1'b0, 4'd0);
        else if (kw_alive[0] && bare_len == 4)
            emit_event(tsp_pkg::K_NULL, 8'd0, 1'b0, 4'd0);
        else if (kw_alive[1] && bare_len == 4)
            emit_event(tsp_pkg::K_BOOL, 8'd0, 1'b1, 4'd0);
        else if (kw_alive[2] && bare_len == 5)
            emit_event(tsp_pkg::K_BOOL, 8'd0, 1'b0, 4'd0);
        else
            raise_error(tsp_pkg::E_BAD_TOKEN);
    endfunction

    function automatic void between_tokens(byte unsigned c);
        int r;
        lx_mode = tsp_pkg::M_IDLE;
        if (c == " " || c == 8'd9 || c == 8'd10 || c == 8'd13)
            return;
        if (c == 0)
        begin
            emit_event(tsp_pkg::K_END_DOC, 8'd0, 1'b0, 4'd0);
            new_document();
            return;
        end
        case (c)
            "/": lx_mode = tsp_pkg::M_SLASH;
            "{": open_level(1'b1);
            "[": open_level(1'b0);
            "}": close_level(1'b1);
            "]": close_level(1'b0);
            ",": r = accept_token(TK_COMMA);
            ":": r = accept_token(TK_COLON);
            "\"":
            begin
                r = accept_token(TK_STRING);
                if (r == 1)
                begin
                    lx_mode = tsp_pkg::M_STRV;
                    value_done();
                end
                else if (r == 2)
                begin
                    lx_mode     = tsp_pkg::M_STRN;
                    want        = tsp_pkg::EX_COLON;
                    just_opened = 1'b0;
                end
            end
            default:
            begin
                if (!is_bare_byte(c))
                    raise_error(tsp_pkg::E_BAD_TOKEN);
                else if (accept_token(TK_BARE) == 1)
                begin
                    lx_mode  = tsp_pkg::M_BARE;
                    first_ch = c;
                    saw_dot  = 1'b0;
                    kw_alive = 3'b111;
                    bare_len = 0;
                    value_done();
                    bare_char(c);
                end
            end
        endcase
    endfunction

    function automatic int decode_escape(byte unsigned c);
        case (c)
            "\\", "/", "\"": return c;
            "b": return 8;
            "f": return 12;
            "n": return 10;
            "r": return 13;
            "t": return 9;
            default: return 256;
        endcase
    endfunction

    // Work out the events one accepted byte causes and queue them.
    function automatic void tokenize_byte(byte unsigned c);
        int d;
        if (err_seen)
            return;
        byte_events.delete();
        case (lx_mode)
            tsp_pkg::M_SLASH:
            begin
                if (c == "/")
                    lx_mode = tsp_pkg::M_LINE;
                else if (c == "*")
                    lx_mode = tsp_pkg::M_BLOCK;
                else
                    raise_error(tsp_pkg::E_SLASH);
            end
            tsp_pkg::M_LINE:
            begin
                if (c == 0)
                    between_tokens(c);
                else if (c == 8'd10)
                    lx_mode = tsp_pkg::M_IDLE;
            end
            tsp_pkg::M_BLOCK:
            begin
                if (c == 0)
                    raise_error(tsp_pkg::E_OPEN_CMT);
                else if (c == "*")
                    lx_mode = tsp_pkg::M_STAR;
            end
            tsp_pkg::M_STAR:
            begin
                if (c == 0)
                    raise_error(tsp_pkg::E_OPEN_CMT);
                else if (c == "/")
                    lx_mode = tsp_pkg::M_IDLE;
                else if (c != "*")
                    lx_mode = tsp_pkg::M_BLOCK;
            end
            tsp_pkg::M_STRV, tsp_pkg::M_STRN:
            begin
                if (c == 0)
                    raise_error(tsp_pkg::E_OPEN_STR);
                else if (c == "\"")
                begin
                    emit_event(lx_mode == tsp_pkg::M_STRN ? tsp_pkg::K_NAME_END
                                                          : tsp_pkg::K_STR_END,
                               8'd0, 1'b0, 4'd0);
                    lx_mode = tsp_pkg::M_IDLE;
                end
                else if (c == "\\")
                    lx_mode = (lx_mode == tsp_pkg::M_STRN) ? tsp_pkg::M_ESCN
                                                           : tsp_pkg::M_ESCV;
                else
                    emit_event(tsp_pkg::K_CONTENT, c, 1'b0, 4'd0);
            end
            tsp_pkg::M_ESCV, tsp_pkg::M_ESCN:
            begin
                d = decode_escape(c);
                if (d > 255)
                    raise_error(tsp_pkg::E_ESCAPE);
                else
                begin
                    emit_event(tsp_pkg::K_CONTENT, d[7:0], 1'b0, 4'd0);
                    lx_mode = (lx_mode == tsp_pkg::M_ESCN) ? tsp_pkg::M_STRN
                                                           : tsp_pkg::M_STRV;
                end
            end
            tsp_pkg::M_BARE:
            begin
                if (is_bare_byte(c))
                    bare_char(c);
                else
                begin
                    finish_bare();
                    if (!err_seen)
                        between_tokens(c);
                end
            end
            default: between_tokens(c);
        endcase
        if (byte_events.size() > 0)
            byte_events[$].last = 1'b1;
        foreach (byte_events[i])
            pending_events.push_back(byte_events[i]);
    endfunction

    // ---------------- driver and monitor ----------------

    // Drive the next text byte and the sink's ready at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || byte_taken)
            begin
                if (text_q.size() > 0 && !hold_input && (steady || $urandom_range(0, 99) >= 18))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 18);
        end
        byte_taken = 1'b0;
    end

    // Predict on each accepted byte, then check each event beat.
    always @(posedge clk)
    begin
        event_t e;
        if (rst_n && s_tvalid && s_tready)
        begin
            byte_taken = 1'b1;
            tokenize_byte(s_tdata);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event beat: tdata=%h tlast=%b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                e = pending_events.pop_front();
                if (m_tdata[3:0] !== e.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", e.kind, m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[11:4] !== e.data)
                begin
                    $error("content_byte: expected %h, got %h", e.data, m_tdata[11:4]);
                    fail_count++;
                end
                if (m_tdata[12] !== e.bval)
                begin
                    $error("bool_value: expected %b, got %b", e.bval, m_tdata[12]);
                    fail_count++;
                end
                if (m_tdata[16:13] !== e.err)
                begin
                    $error("error_code: expected %0d, got %0d", e.err, m_tdata[16:13]);
                    fail_count++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_of_run: expected %b, got %b", e.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- text generation ----------------

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Drop whitespace or a comment between tokens now and then.
    task automatic put_gap();
        int r;
        byte unsigned b;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            case ($urandom_range(0, 3))
                0: text_q.push_back(8'd32);
                1: text_q.push_back(8'd9);
                2: text_q.push_back(8'd10);
                default: text_q.push_back(8'd13);
            endcase
        end
        else if (r == 3)
        begin
            put_text("//");
            repeat ($urandom_range(0, 3))
            begin
                b = $urandom_range(1, 255);
                text_q.push_back(b == 8'd10 ? 8'd32 : b);
            end
            text_q.push_back(8'd10);
        end
        else if (r == 4)
        begin
            put_text("/*");
            repeat ($urandom_range(0, 3))
            begin
                b = $urandom_range(1, 255);
                text_q.push_back(b == "*" ? "a" : b);
            end
            if ($urandom_range(0, 1) != 0)
                put_text("**/");
            else
                put_text("*/");
        end
    endtask

    task automatic put_string();
        byte unsigned b;
        string esc;
        esc = "\\/\"bfnrt";
        text_q.push_back("\"");
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                text_q.push_back("\\");
                text_q.push_back(esc[$urandom_range(0, 7)]);
            end
            else
            begin
                b = $urandom_range(1, 255);
                if (b == "\"" || b == "\\")
                    b = "x";
                text_q.push_back(b);
            end
        end
        text_q.push_back("\"");
    endtask

    task automatic put_number();
        string lead;
        string tail;
        lead = "0123456789+-.-";
        tail = "0123456789.eE";
        text_q.push_back(lead[$urandom_range(0, 13)]);
        repeat ($urandom_range(0, 4))
            text_q.push_back(tail[$urandom_range(0, 12)]);
    endtask

    // room: how many more levels may still be opened
    task automatic put_value(int room);
        int r;
        int n;
        r = $urandom_range(0, 9);
        n = $urandom_range(0, 3);
        if (room > 0 && r < 2)
        begin
            text_q.push_back("{");
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    text_q.push_back(",");
                put_gap();
                put_string();
                put_gap();
                text_q.push_back(":");
                put_gap();
                put_value(room - 1);
                put_gap();
            end
            text_q.push_back("}");
        end
        else if (room > 0 && r < 4)
        begin
            text_q.push_back("[");
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    text_q.push_back(",");
                put_gap();
                put_value(room - 1);
                put_gap();
            end
            text_q.push_back("]");
        end
        else if (r < 6)
            put_string();
        else if (r < 8)
            put_number();
        else
            put_text(kw_word[$urandom_range(0, 2)]);
    endtask

    // One document: a few top-level values, then the terminating zero byte.
    task automatic put_document(int room);
        repeat ($urandom_range(1, 3))
        begin
            put_gap();
            put_value(room);
            text_q.push_back(" ");
        end
        put_gap();
        text_q.push_back(8'd0);
    endtask

    task automatic put_nested(int levels);
        repeat (levels)
            text_q.push_back("[");
        text_q.push_back("7");
        repeat (levels)
            text_q.push_back("]");
        text_q.push_back(8'd0);
    endtask

    // Close the run with one malformed tail; the parser latches the first error.
    task automatic put_broken_tail(int cap);
        case ($urandom_range(0, 10))
            0: put_text("[1,,");
            1: put_text("{\"a\" 1");
            2: put_text("{7:");
            3: put_text("/x");
            4: put_text("/* open");
            5: put_text("\"open");
            6: put_text("\"a\\q");
            7: put_text("nulx ");
            8: put_text("#");
            9: repeat (cap + 1) text_q.push_back("[");
            default: put_text("[1}");
        endcase
        text_q.push_back(8'd0);
        put_text("[1]");
    endtask

    // ---------------- sequencing ----------------

    task automatic wait_drained();
        while (text_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [5:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n_bytes, int room);
        int start;
        start = text_q.size();
        while (text_q.size() - start < n_bytes)
            put_document(room);
    endtask

    initial
    begin
        logic [5:0] lim;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        hold_input = 1'b0;
        steady     = 1'b0;
        byte_taken = 1'b0;
        fail_count = 0;
        limit_reg  = tsp_pkg::NEST_LIMIT_RESET;
        lvl_is_obj = '{default: 1'b0};
        err_seen   = 1'b0;
        new_document();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every event kind but signed and error, all escapes, comments, keywords.
        put_text("{\"a\\/\":-1.5,\"b\":[null,true,false,+7,9]}");
        text_q.push_back(8'd0);
        put_text("\"\\\\\\\"\\b\\f\\n\\r\\t\xff\" /**/ 3 //c");
        text_q.push_back(8'd0);

        // Tight limit: only one level deep.
        write_limit(6'd1);
        run_random(10, 1);

        // Deepest allowed nesting, no idling on either side.
        write_limit(6'd32);
        steady = 1'b1;
        put_nested(32);
        run_random(20, 4);
        wait_drained();
        steady = 1'b0;

        lim = $urandom_range(2, 31);
        write_limit(lim);
        put_nested(lim);
        run_random(20, 3);

        // Hold the sender off until every event is back, then resume.
        hold_input = 1'b1;
        while (pending_events.size() > 0)
            @(posedge clk);
        hold_input = 1'b0;
        run_random(20, 3);

        lim = $urandom_range(1, 32);
        write_limit(lim);
        run_random(20, 3);
        put_broken_tail(lim);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
            $display("tb_json_token_stream_parser: PASS");
        else
            $display("tb_json_token_stream_parser: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_json_token_stream_parser: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tsp_pkg.sv
rtl/core/tsp_front.sv
rtl/core/tsp_queue.sv
rtl/core/tsp_back.sv
rtl/core/json_token_stream_parser.sv
tb/sv/tb_json_token_stream_parser.sv
